[rtl/trle_pkg.sv]
// Shared types, constants and helpers of the threshold run-length encoder.
// No dependencies; every other file of the block imports this package.
package trle_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int MAX_LEN     = 65536;
  // Counters must hold MAX_LEN + 1 so that the element count can flag overflow.
  localparam int CNT_W       = $clog2(MAX_LEN + 2);

  // A classified sample on its way from the front to the back.
  typedef struct packed {
    logic [VALUE_WIDTH-1:0] sample;
    logic                   keep;
    logic                   last;
  } item_t;

  // One result as it is queued for the output.
  typedef struct packed {
    logic                   kind;
    logic [VALUE_WIDTH-1:0] kept_value;
    logic [CNT_W-1:0]       run_length;
    logic                   first_run_kept;
    logic [CNT_W-1:0]       kept_total;
    logic [CNT_W-1:0]       run_total;
    logic                   overflow;
    logic                   final_res;
  } res_t;

  localparam logic KIND_KEPT = 1'b0;
  localparam logic KIND_RUN  = 1'b1;

  // Count up, holding at MAX_LEN.
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v < CNT_W'(MAX_LEN)) ? v + 1'b1 : CNT_W'(MAX_LEN);
  endfunction

endpackage

[rtl/trle_front.sv]
// Front end: threshold register, sample classification and the item queue.
// Depends on trle_pkg.
module trle_front import trle_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  logic [VALUE_WIDTH-1:0] sample,
  input  logic                   end_of_vector,
  output logic                   full,
  input  logic                   threshold_we,
  input  logic [VALUE_WIDTH-1:0] threshold_wdata,
  output logic                   item_valid,
  output item_t                  item,
  input  logic                   item_pop
);

  logic [VALUE_WIDTH-1:0] threshold;
  item_t                  slots [2];
  logic                   wp;
  logic                   rp;
  logic [1:0]             count;
  logic                   accept;
  item_t                  incoming;

  assign full       = (count == 2'd2);
  assign accept     = push && !full;
  assign item_valid = (count != 2'd0);
  assign item       = slots[rp];

  // Classify: keep anything at or above the threshold.
  always_comb begin
    incoming.sample = sample;
    incoming.keep   = ($signed(sample) >= $signed(threshold));
    incoming.last   = end_of_vector;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= '0;
      wp        <= 1'b0;
      rp        <= 1'b0;
      count     <= 2'd0;
    end else begin
      if (threshold_we) begin
        threshold <= threshold_wdata;
      end
      if (accept) begin
        wp <= ~wp;
      end
      if (item_pop) begin
        rp <= ~rp;
      end
      count <= count + 2'(accept) - 2'(item_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slots[wp] <= incoming;
    end
  end

endmodule

[rtl/trle_res_queue.sv]
// Two-entry result queue that parts the back end from the output handshake.
// Depends on trle_pkg.
module trle_res_queue import trle_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  res_t wdata,
  output logic space,
  input  logic pop,
  output logic empty,
  output res_t head
);

  res_t       slots [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;
  logic       rd;

  assign space = (count != 2'd2);
  assign empty = (count == 2'd0);
  assign rd    = pop && !empty;
  assign head  = slots[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr) begin
        wp <= ~wp;
      end
      if (rd) begin
        rp <= ~rp;
      end
      count <= count + 2'(wr) - 2'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wp] <= wdata;
    end
  end

endmodule

[rtl/trle_back.sv]
// Back end: run tracking and result sequencing, one result per cycle unless stalled.
// Depends on trle_pkg.
module trle_back import trle_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  item_valid,
  input  item_t item,
  output logic  item_pop,
  output logic  res_wr,
  output res_t  res,
  input  logic  res_space
);

  typedef enum logic [1:0] {PH_HEAD, PH_KEPT, PH_FINAL} phase_t;

  phase_t           phase, phase_next;
  logic             at_start, at_start_next;
  logic             cur_kept, cur_kept_next;
  logic [CNT_W-1:0] run_len, run_len_next;
  logic             first_kept, first_kept_next;
  logic [CNT_W-1:0] kept_cnt, kept_cnt_next;
  logic [CNT_W-1:0] runs, runs_next;
  logic [CNT_W-1:0] elems, elems_next;
  logic             emit;
  logic             done;
  logic             go;

  always_comb begin
    phase_next      = phase;
    at_start_next   = at_start;
    cur_kept_next   = cur_kept;
    run_len_next    = run_len;
    first_kept_next = first_kept;
    kept_cnt_next   = kept_cnt;
    runs_next       = runs;
    elems_next      = elems;
    emit            = 1'b0;
    done            = 1'b0;
    res             = '0;
    case (phase)
      PH_HEAD: begin
        elems_next = (elems <= CNT_W'(MAX_LEN)) ? elems + 1'b1 : elems;
        if (at_start) begin
          at_start_next   = 1'b0;
          first_kept_next = item.keep;
          cur_kept_next   = item.keep;
          run_len_next    = CNT_W'(1);
        end else if (item.keep == cur_kept) begin
          run_len_next = sat_inc(run_len);
        end else begin
          // Kind changed: close the running run.
          emit               = 1'b1;
          runs_next          = sat_inc(runs);
          res.kind           = KIND_RUN;
          res.run_length     = run_len;
          res.first_run_kept = first_kept;
          res.kept_total     = kept_cnt;
          res.run_total      = runs_next;
          res.overflow       = (elems_next > CNT_W'(MAX_LEN));
          cur_kept_next      = item.keep;
          run_len_next       = CNT_W'(1);
        end
        if (item.keep) begin
          phase_next = PH_KEPT;
        end else if (item.last) begin
          phase_next = PH_FINAL;
        end else begin
          done = 1'b1;
        end
      end
      PH_KEPT: begin
        emit               = 1'b1;
        kept_cnt_next      = sat_inc(kept_cnt);
        res.kind           = KIND_KEPT;
        res.kept_value     = item.sample;
        res.first_run_kept = first_kept;
        res.kept_total     = kept_cnt_next;
        res.run_total      = runs;
        res.overflow       = (elems > CNT_W'(MAX_LEN));
        if (item.last) begin
          phase_next = PH_FINAL;
        end else begin
          done = 1'b1;
        end
      end
      PH_FINAL: begin
        emit               = 1'b1;
        res.kind           = KIND_RUN;
        res.run_length     = run_len;
        res.first_run_kept = first_kept;
        res.kept_total     = kept_cnt;
        res.run_total      = sat_inc(runs);
        res.overflow       = (elems > CNT_W'(MAX_LEN));
        res.final_res      = 1'b1;
        // Drop back to the start state for the next vector.
        at_start_next      = 1'b1;
        cur_kept_next      = 1'b0;
        run_len_next       = '0;
        first_kept_next    = 1'b0;
        kept_cnt_next      = '0;
        runs_next          = '0;
        elems_next         = '0;
        done               = 1'b1;
      end
      default: begin
        done = 1'b1;
      end
    endcase
    if (done) begin
      phase_next = PH_HEAD;
    end
  end

  // Hold the step while its result has nowhere to go.
  assign go       = item_valid && (!emit || res_space);
  assign res_wr   = go && emit;
  assign item_pop = go && done;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HEAD;
      at_start   <= 1'b1;
      cur_kept   <= 1'b0;
      run_len    <= '0;
      first_kept <= 1'b0;
      kept_cnt   <= '0;
      runs       <= '0;
      elems      <= '0;
    end else if (go) begin
      phase      <= phase_next;
      at_start   <= at_start_next;
      cur_kept   <= cur_kept_next;
      run_len    <= run_len_next;
      first_kept <= first_kept_next;
      kept_cnt   <= kept_cnt_next;
      runs       <= runs_next;
      elems      <= elems_next;
    end
  end

endmodule

[rtl/threshold_run_length_encoder.sv]
// Threshold run-length encoder, top level.
// Depends on trle_pkg, trle_front, trle_back and trle_res_queue.
//
// Samples stream in as requests on a queue-style port (push/full), the last
// one of each vector flagged by end_of_vector. Each sample at or above the
// signed threshold is passed out as a kind 0 result; whenever the run of
// kept or dropped samples changes kind, and at the end of the vector, the
// finished run length goes out as a kind 1 result, the last one of a vector
// carrying final_res and the vector totals. Every result also carries the
// running totals, the first-run flag and the overflow flag, which rises once
// a vector exceeds MAX_LEN samples. Counts saturate at MAX_LEN. The front
// classifies a sample in the cycle it is taken and parks it in a two-entry
// queue; the back sequencer then takes each sample through a head step,
// which closes the running run when the kind changes, a step that passes
// out the value of a kept sample, and, at the end of a vector, a step that
// closes the last run. Results wait in a two-entry queue read with
// empty/pop, so the front keeps taking requests while the output is
// stalled, until its own two-entry queue fills. The threshold is written
// through threshold_we/threshold_wdata and applies to samples taken
// afterwards; write it only while no vector is in flight.
module threshold_run_length_encoder import trle_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic signed [VALUE_WIDTH-1:0] sample,
  input  logic                          end_of_vector,
  input  logic                          threshold_we,
  input  logic signed [VALUE_WIDTH-1:0] threshold_wdata,
  output logic                          empty,
  input  logic                          pop,
  output logic                          kind,
  output logic signed [VALUE_WIDTH-1:0] kept_value,
  output logic        [CNT_W-1:0]       run_length,
  output logic                          first_run_kept,
  output logic        [CNT_W-1:0]       kept_total,
  output logic        [CNT_W-1:0]       run_total,
  output logic                          overflow,
  output logic                          final_res
);

  logic  item_valid;
  item_t item;
  logic  item_pop;
  logic  res_wr;
  res_t  res;
  logic  res_space;
  res_t  head;

  // Front: take requests, compare against the threshold, queue them.
  trle_front u_front (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .sample          (sample),
    .end_of_vector   (end_of_vector),
    .full            (full),
    .threshold_we    (threshold_we),
    .threshold_wdata (threshold_wdata),
    .item_valid      (item_valid),
    .item            (item),
    .item_pop        (item_pop)
  );

  // Back: track runs and emit results one at a time.
  trle_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .res_wr     (res_wr),
    .res        (res),
    .res_space  (res_space)
  );

  // Output side: hold results until the consumer pops them.
  trle_res_queue u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (res_wr),
    .wdata (res),
    .space (res_space),
    .pop   (pop),
    .empty (empty),
    .head  (head)
  );

  assign kind           = head.kind;
  assign kept_value     = head.kept_value;
  assign run_length     = head.run_length;
  assign first_run_kept = head.first_run_kept;
  assign kept_total     = head.kept_total;
  assign run_total      = head.run_total;
  assign overflow       = head.overflow;
  assign final_res      = head.final_res;

  // Never write a result into a full queue.
  a_no_res_overrun: assert property (@(posedge clk) disable iff (rst)
    res_wr |-> res_space)
    else $error("result written while result queue full");

  // Only retire an item that is actually queued.
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    item_pop |-> item_valid)
    else $error("item retired from empty item queue");

  // A closing result is always a run length.
  a_final_is_run: assert property (@(posedge clk) disable iff (rst)
    (res_wr && res.final_res) |-> (res.kind == KIND_RUN))
    else $error("final result is not a run length");

  // After reset the result queue is empty and the item queue is not full.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("queues not empty after reset");

endmodule
